### rtl/fifo_cpu_dispatcher_core_macros.svh
// Assertion macros shared by the dispatcher RTL.
`ifndef FIFO_CPU_DISPATCHER_CORE_MACROS_SVH
`define FIFO_CPU_DISPATCHER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed by another on the next edge.
`define FCD_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

### rtl/fcd_pkg.sv
// Types, codes and constants of the CPU job dispatcher.
package fcd_pkg;

	localparam int DEF_MAX_CPUS    = 8;
	localparam int DEF_QUEUE_DEPTH = 64;
	localparam int TAG_W           = 16;
	localparam int CMD_DEPTH       = 2;
	localparam logic [3:0] CFG_RESET = 4'd8;

	localparam logic [1:0] FUNC_REQ   = 2'd0;
	localparam logic [1:0] FUNC_DONE  = 2'd1;
	localparam logic [1:0] FUNC_STATE = 2'd2;

	localparam logic [2:0] KIND_DISPATCH   = 3'd0;
	localparam logic [2:0] KIND_FORWARD    = 3'd1;
	localparam logic [2:0] KIND_SPEED_UP   = 3'd2;
	localparam logic [2:0] KIND_IDLE       = 3'd3;
	localparam logic [2:0] KIND_RESPONSE   = 3'd4;
	localparam logic [2:0] KIND_INDEX_ERR  = 3'd5;
	localparam logic [2:0] KIND_QUEUE_FULL = 3'd6;

	typedef struct packed {
		logic [1:0]       func;
		logic [TAG_W-1:0] job_tag;
		logic [3:0]       done_cpu;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [2:0]       target_cpu;
		logic [TAG_W-1:0] out_tag;
		logic             last;
	} out_item_t;

	typedef enum logic [2:0] {
		COP_DISPATCH,
		COP_FULL,
		COP_FORWARD,
		COP_ERR,
		COP_SPEED,
		COP_IDLE
	} cop_t;

	typedef struct packed {
		cop_t             cop;
		logic [2:0]       cpu;
		logic [TAG_W-1:0] tag;
		logic [TAG_W-1:0] next_tag;
	} cmd_t;

endpackage

### rtl/fifo_cpu_dispatcher_core.sv
// Top level of the first-idle-CPU job dispatcher with a wait queue.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  req     | in        | req_valid/req_stall | func, job_tag, done_cpu
//  rsp     | out       | rsp_valid/rsp_stall | kind, target_cpu, out_tag, last
//  cfg     | in        | cfg_we              | cfg_wdata = cpus_in_use
//
//  Front end handles an item in two states: F_IDLE captures it, F_EXEC runs
//  it against the idle mask and wait queue (the head tag is prefetched from
//  the wait store's registered read port during the capture cycle). It takes
//  no new item until F_EXEC ends; F_EXEC waits while the command queue is full.
//  Back end sends 1 to 3 results per command, one per cycle unless rsp_stall is set.
//  A two-entry command queue lets rsp_stall back up without halting the front
//  until that queue fills. Reset marks all CPUs idle, clears the pointers and
//  counts; the wait store needs no clearing pass.
module fifo_cpu_dispatcher_core import fcd_pkg::*; #(
	parameter int MAX_CPUS    = DEF_MAX_CPUS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  in_item_t   req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output out_item_t  rsp,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata
);

	// front to queue
	cmd_t push_cmd;
	logic cmd_push;
	logic cmd_full;
	// queue to back
	cmd_t head_cmd;
	logic cmd_pop;
	logic cmd_empty;

	// classify items and update the dispatch state
	fcd_front #(
		.MAX_CPUS   (MAX_CPUS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (push_cmd),
		.cmd_push (cmd_push),
		.cmd_full (cmd_full)
	);

	// decouple the two halves
	fcd_cmd_fifo u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wr_cmd(push_cmd),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rd_cmd(head_cmd),
		.empty (cmd_empty)
	);

	// expand commands into result items behind an output register
	fcd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (head_cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

### rtl/fcd_front.sv
// Front end: accepts items, owns the idle mask and wait queue, issues commands.
`include "fifo_cpu_dispatcher_core_macros.svh"

module fcd_front import fcd_pkg::*; #(
	parameter int MAX_CPUS    = DEF_MAX_CPUS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  in_item_t req,
	input  logic     cfg_we,
	input  logic [3:0] cfg_wdata,
	output cmd_t     cmd,
	output logic     cmd_push,
	input  logic     cmd_full
);

	localparam int CPU_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int QW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_EXEC = 2'b10
	} fstate_t;

	fstate_t             state_q;
	in_item_t            item_q;
	logic [3:0]          cpus_q;
	logic [MAX_CPUS-1:0] mask_q;
	logic [QW-1:0]       head_q;
	logic [QW-1:0]       tail_q;
	logic [CW-1:0]       count_q;
	logic [TAG_W-1:0]    mem [QUEUE_DEPTH];
	logic [TAG_W-1:0]    rd_q;

	logic [4:0]          n_eff;
	logic                found;
	logic [CPU_W-1:0]    idx;
	logic [CPU_W-1:0]    done_idx;
	logic                need_push;
	logic                advance;
	logic                do_enq;
	logic                do_deq;
	logic                do_clr_found;
	logic                do_clr_done;
	logic                do_set_done;

	assign req_stall = (state_q != F_IDLE);

	always_comb begin
		if (cpus_q == 4'd0) begin
			n_eff = 5'd1;
		end else if ({1'b0, cpus_q} > 5'(MAX_CPUS)) begin
			n_eff = 5'(MAX_CPUS);
		end else begin
			n_eff = {1'b0, cpus_q};
		end
	end

	// lowest-numbered idle CPU within the active count
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = MAX_CPUS - 1; i >= 0; i--) begin
			if (mask_q[i] && (5'(i) < n_eff)) begin
				found = 1'b1;
				idx   = CPU_W'(i);
			end
		end
	end

	assign done_idx = CPU_W'(item_q.done_cpu);

	always_comb begin
		cmd          = '{cop: COP_FORWARD, cpu: 3'd0, tag: item_q.job_tag, next_tag: rd_q};
		need_push    = 1'b0;
		do_enq       = 1'b0;
		do_deq       = 1'b0;
		do_clr_found = 1'b0;
		do_clr_done  = 1'b0;
		do_set_done  = 1'b0;
		unique case (item_q.func)
			FUNC_REQ: begin
				if (found) begin
					cmd.cop      = COP_DISPATCH;
					cmd.cpu      = 3'(idx);
					need_push    = 1'b1;
					do_clr_found = 1'b1;
				end else if (count_q == CW'(QUEUE_DEPTH)) begin
					cmd.cop   = COP_FULL;
					need_push = 1'b1;
				end else begin
					do_enq = 1'b1;
				end
			end
			FUNC_DONE: begin
				need_push = 1'b1;
				cmd.cpu   = 3'(done_idx);
				if ({1'b0, item_q.done_cpu} >= n_eff) begin
					cmd.cop = COP_ERR;
					cmd.cpu = 3'd0;
				end else if (count_q != '0) begin
					cmd.cop     = COP_SPEED;
					do_deq      = 1'b1;
					do_clr_done = 1'b1;
				end else begin
					cmd.cop     = COP_IDLE;
					do_set_done = 1'b1;
				end
			end
			FUNC_STATE: begin
				cmd.cop   = COP_FORWARD;
				need_push = 1'b1;
			end
			default: begin
				need_push = 1'b0;
			end
		endcase
	end

	assign advance  = (state_q == F_EXEC) && (!need_push || !cmd_full);
	assign cmd_push = advance && need_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cpus_q  <= CFG_RESET;
			mask_q  <= '1;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				cpus_q <= cfg_wdata;
			end
			unique case (state_q)
				F_IDLE: begin
					if (req_valid) begin
						state_q <= F_EXEC;
					end
				end
				F_EXEC: begin
					if (advance) begin
						state_q <= F_IDLE;
						if (do_clr_found) begin
							mask_q[idx] <= 1'b0;
						end
						if (do_clr_done) begin
							mask_q[done_idx] <= 1'b0;
						end
						if (do_set_done) begin
							mask_q[done_idx] <= 1'b1;
						end
						if (do_enq) begin
							tail_q  <= (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
							count_q <= count_q + 1'b1;
						end
						if (do_deq) begin
							head_q  <= (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
							count_q <= count_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && req_valid) begin
			item_q <= req;
		end
	end

	// wait store: write the tail on enqueue, prefetch the head every cycle
	always_ff @(posedge clk) begin
		if (advance && do_enq) begin
			mem[tail_q] <= item_q.job_tag;
		end
		rd_q <= mem[head_q];
	end

	`FCD_ASSERT(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "wait count beyond queue depth")
	`FCD_ASSERT(a_empty_ptrs, (count_q != '0) || (head_q == tail_q), "empty queue with split pointers")
	`FCD_ASSERT_NEXT(a_exec_done, advance, state_q == F_IDLE, "front did not return to idle")

endmodule

### rtl/fcd_cmd_fifo.sv
// Short command queue between front and back end.
`include "fifo_cpu_dispatcher_core_macros.svh"

module fcd_cmd_fifo import fcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic empty
);

	localparam int PW = $clog2(CMD_DEPTH);
	localparam int NW = $clog2(CMD_DEPTH + 1);

	cmd_t          slot_q [CMD_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] cnt_q;

	assign full   = (cnt_q == NW'(CMD_DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_cmd = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(CMD_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(CMD_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wr_cmd;
		end
	end

	`FCD_ASSERT(a_no_overflow, !(push && full), "command pushed into full queue")

endmodule

### rtl/fcd_back.sv
// Back end: expands each command into one to three result items.
`include "fifo_cpu_dispatcher_core_macros.svh"

module fcd_back import fcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	logic [1:0] step_q;
	logic       valid_q;
	out_item_t  out_q;
	out_item_t  res;
	out_item_t  resp_item;
	logic       load;

	assign resp_item = '{kind: KIND_RESPONSE, target_cpu: 3'd0, out_tag: cmd.tag, last: 1'b1};

	always_comb begin
		res = resp_item;
		unique case (cmd.cop)
			COP_DISPATCH: res = '{KIND_DISPATCH, cmd.cpu, cmd.tag, 1'b1};
			COP_FULL:     res = '{KIND_QUEUE_FULL, 3'd0, cmd.tag, 1'b1};
			COP_FORWARD:  res = '{KIND_FORWARD, 3'd0, cmd.tag, 1'b1};
			COP_ERR: begin
				if (step_q == 2'd0) res = '{KIND_INDEX_ERR, 3'd0, cmd.tag, 1'b0};
			end
			COP_SPEED: begin
				if (step_q == 2'd0) begin
					res = '{KIND_SPEED_UP, cmd.cpu, '0, 1'b0};
				end else if (step_q == 2'd1) begin
					res = '{KIND_DISPATCH, cmd.cpu, cmd.next_tag, 1'b0};
				end
			end
			COP_IDLE: begin
				if (step_q == 2'd0) res = '{KIND_IDLE, cmd.cpu, '0, 1'b0};
			end
			default: res = resp_item;
		endcase
	end

	assign load      = !cmd_empty && (!valid_q || !rsp_stall);
	assign cmd_pop   = load && res.last;
	assign rsp_valid = valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q  <= res.last ? 2'd0 : step_q + 2'd1;
			end else if (!rsp_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	`FCD_ASSERT(a_step_has_cmd, (step_q == 2'd0) || !cmd_empty, "command left mid-expansion")

endmodule

### test/fifo_cpu_dispatcher_core_checker.sv
`timescale 1ns / 1ps
// Checker of the CPU job dispatcher: predicts each result item and compares it on arrival.
module fifo_cpu_dispatcher_core_checker import fcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_stall,
	input  in_item_t   req,
	input  logic       rsp_valid,
	input  logic       rsp_stall,
	input  out_item_t  rsp,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	output int         errors,
	output int         pending
);

	logic [3:0]                cpus_setting;
	logic [DEF_MAX_CPUS-1:0]   idle_cpus;
	logic [TAG_W-1:0]          job_backlog[$];
	out_item_t                 owed_results[$];

	function automatic void owe(input logic [2:0] kind, input logic [2:0] cpu,
			input logic [TAG_W-1:0] tag, input logic last);
		out_item_t r;
		r.kind       = kind;
		r.target_cpu = cpu;
		r.out_tag    = tag;
		r.last       = last;
		owed_results.push_back(r);
	endfunction

	// Work out the result items of one accepted item and advance the model state.
	function automatic void dispatch_job(input in_item_t it);
		int               n;
		bit               placed;
		logic [TAG_W-1:0] head;
		n = (cpus_setting == 4'd0) ? 1 :
			(cpus_setting > DEF_MAX_CPUS) ? DEF_MAX_CPUS : int'(cpus_setting);
		case (it.func)
			FUNC_REQ: begin
				placed = 1'b0;
				for (int i = 0; i < n && !placed; i++) begin
					if (idle_cpus[i]) begin
						idle_cpus[i] = 1'b0;
						owe(KIND_DISPATCH, 3'(i), it.job_tag, 1'b1);
						placed = 1'b1;
					end
				end
				if (!placed) begin
					if (job_backlog.size() >= DEF_QUEUE_DEPTH)
						owe(KIND_QUEUE_FULL, 3'd0, it.job_tag, 1'b1);
					else
						job_backlog.push_back(it.job_tag);
				end
			end
			FUNC_STATE: owe(KIND_FORWARD, 3'd0, it.job_tag, 1'b1);
			FUNC_DONE: begin
				if (int'(it.done_cpu) >= n) begin
					owe(KIND_INDEX_ERR, 3'd0, it.job_tag, 1'b0);
				end else if (job_backlog.size() > 0) begin
					head = job_backlog.pop_front();
					idle_cpus[it.done_cpu] = 1'b0;
					owe(KIND_SPEED_UP, it.done_cpu[2:0], '0, 1'b0);
					owe(KIND_DISPATCH, it.done_cpu[2:0], head, 1'b0);
				end else begin
					idle_cpus[it.done_cpu] = 1'b1;
					owe(KIND_IDLE, it.done_cpu[2:0], '0, 1'b0);
				end
				owe(KIND_RESPONSE, 3'd0, it.job_tag, 1'b1);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			errors       = 0;
			cpus_setting = CFG_RESET;
			idle_cpus    = '1;
			job_backlog.delete();
			owed_results.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected rsp kind %0d cpu %0d tag %h last %b", $time,
						rsp.kind, rsp.target_cpu, rsp.out_tag, rsp.last);
				end else begin
					want = owed_results.pop_front();
					if (rsp !== want) begin
						errors++;
						$display("%0t: expected %0d/%0d/%h/%b, got %0d/%0d/%h/%b",
							$time, want.kind, want.target_cpu, want.out_tag, want.last,
							rsp.kind, rsp.target_cpu, rsp.out_tag, rsp.last);
					end
				end
			end
			if (cfg_we)
				cpus_setting = cfg_wdata;
			if (req_valid && !req_stall)
				dispatch_job(req);
		end
		pending = owed_results.size();
	end

endmodule

### test/fifo_cpu_dispatcher_core_test.sv
`timescale 1ns / 1ps
// Testbench top of the CPU job dispatcher: stimulus, flow control and the verdict.
module fifo_cpu_dispatcher_core_test import fcd_pkg::*;;

	// Unused function code; the block must drop such an item without a trace.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// Quiet cycles after the last result: the front end may still be busy
	// queueing a job, which gives no result.
	localparam int SETTLE_CYCLES = 12;
	// Worst case per item is about 3 results each behind the longest stall plus
	// the longest sender gap; take that several times over.
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 55;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	in_item_t   req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	out_item_t  rsp;
	logic       cfg_we = 1'b0;
	logic [3:0] cfg_wdata = CFG_RESET;
	int         mismatches;
	int         owed;
	int unsigned cycles = 0;
	bit         sender_calm = 1'b0;
	int         stall_left = 0;
	int         flow_left = 0;

	fifo_cpu_dispatcher_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	fifo_cpu_dispatcher_core_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (mismatches),
		.pending   (owed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hold the run to a bounded number of cycles; a hang is a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("fifo_cpu_dispatcher_core_test: FAIL");
			$finish;
		end
	end

	// Gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// Stall the result channel in bursts: a run of free cycles, then a stall
	// of random length. Runs are sometimes long so that results also stream.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			rsp_stall <= 1'b0;
			if (flow_left > 0) begin
				flow_left <= flow_left - 1;
			end else begin
				flow_left <= ($urandom_range(9) == 0) ? $urandom_range(80, 30) :
					$urandom_range(12);
				stall_left <= pick_gap();
			end
		end
	end

	function automatic in_item_t job_item(input logic [1:0] func,
			input logic [TAG_W-1:0] tag, input logic [3:0] cpu);
		in_item_t it;
		it.func     = func;
		it.job_tag  = tag;
		it.done_cpu = cpu;
		return it;
	endfunction

	// Draw one item: requests at the given share, the rest mostly completions
	// aimed at CPUs in use, plus state requests and some unused-code noise.
	function automatic in_item_t random_item(input int req_pct, input int n_cpus);
		in_item_t it;
		int       r;
		it.job_tag  = TAG_W'($urandom);
		it.done_cpu = ($urandom_range(99) < 85) ? 4'($urandom_range(n_cpus - 1)) :
			4'($urandom_range(15));
		r = $urandom_range(99);
		if (r < req_pct) begin
			it.func = FUNC_REQ;
		end else begin
			r = $urandom_range(99);
			it.func = (r < 75) ? FUNC_DONE : (r < 92) ? FUNC_STATE : FUNC_UNUSED;
		end
		return it;
	endfunction

	// Present one item at the falling edge and hold it until it is taken.
	// Keep valid high between back-to-back items; drop it only for a gap.
	task automatic send_item(input in_item_t it);
		int gap;
		gap = sender_calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// Drop valid, wait for every owed result, then let the front end go quiet.
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		wait (owed == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cpus(input logic [3:0] value);
		@(negedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [3:0] settings[6];
		int         req_share[6];
		int         n_cpus;
		int         sent;
		in_item_t   it;

		// Walk from one CPU (queue fills up and overflows) through the
		// saturating setting to mid sizes that drain the backlog.
		settings  = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};
		req_share = '{80, 85, 70, 30, 20, 50};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset setting of eight CPUs.
		send_item(job_item(FUNC_STATE, 16'h0000, 4'd0));
		send_item(job_item(FUNC_STATE, 16'hFFFF, 4'd15));
		send_item(job_item(FUNC_UNUSED, 16'hAAAA, 4'd2));
		// Completion with an index far out of range, then just past the top.
		send_item(job_item(FUNC_DONE, 16'h1234, 4'd15));
		send_item(job_item(FUNC_DONE, 16'h5555, 4'd8));
		// Completion for a CPU that is already idle.
		send_item(job_item(FUNC_DONE, 16'h0000, 4'd0));
		// Fill every CPU, lowest index first.
		for (int i = 0; i < DEF_MAX_CPUS; i++)
			send_item(job_item(FUNC_REQ, (i == 0) ? 16'hFFFF : 16'(i * 16'h2111), 4'(i)));
		// All busy: queue two jobs, then release CPUs to pull them.
		send_item(job_item(FUNC_REQ, 16'hFFFF, 4'd0));
		send_item(job_item(FUNC_REQ, 16'h0001, 4'd0));
		send_item(job_item(FUNC_DONE, 16'hABCD, 4'd7));
		send_item(job_item(FUNC_DONE, 16'h0000, 4'd3));
		// Queue empty now: an idle command, then the CPU is taken again.
		send_item(job_item(FUNC_DONE, 16'h7FFF, 4'd3));
		send_item(job_item(FUNC_REQ, 16'h8000, 4'd0));

		for (int p = 0; p < 6; p++) begin
			settle();
			write_cpus(settings[p]);
			n_cpus = (settings[p] == 4'd0) ? 1 :
				(settings[p] > DEF_MAX_CPUS) ? DEF_MAX_CPUS : int'(settings[p]);
			// Run every third phase without sender gaps.
			sender_calm = (p % 3 == 2);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				it = random_item(req_share[p], n_cpus);
				send_item(it);
				if (it.func != FUNC_UNUSED)
					sent++;
			end
		end

		settle();
		if (mismatches == 0)
			$display("fifo_cpu_dispatcher_core_test: PASS");
		else
			$display("fifo_cpu_dispatcher_core_test: FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/fcd_pkg.sv
rtl/fcd_front.sv
rtl/fcd_cmd_fifo.sv
rtl/fcd_back.sv
rtl/fifo_cpu_dispatcher_core.sv
test/fifo_cpu_dispatcher_core_checker.sv
test/fifo_cpu_dispatcher_core_test.sv
